// File: hw/rtl/p3lmt_pkg.sv
// Shared widths, codes and controller/datapath interface types for the local-maximum tester.
package p3lmt_pkg;

  localparam int COORD_W      = 5;
  localparam int VAL_W        = 32;
  localparam int STAT_W       = 2;
  localparam int GS_W         = 6;
  localparam int MAX_EDGE_DEF = 32;
  localparam int EDGE_MIN     = 3;

  localparam logic [GS_W-1:0] GRID_SIZE_RST = 6'd32;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TEST  = 1'b1;

  localparam logic [STAT_W-1:0] ST_PEAK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEG     = 2'd1;
  localparam logic [STAT_W-1:0] ST_GREATER = 2'd2;
  localparam logic [STAT_W-1:0] ST_OOR     = 2'd3;

  // Per-axis neighbour offset codes
  localparam logic [1:0] OFF_MINUS = 2'd0;
  localparam logic [1:0] OFF_ZERO  = 2'd1;
  localparam logic [1:0] OFF_PLUS  = 2'd2;

  typedef struct packed {
    logic       wr;     // store the accepted write transaction
    logic       start;  // latch the accepted test transaction
    logic       rd;     // issue one store read
    logic [1:0] off_p;
    logic [1:0] off_r;
    logic [1:0] off_c;
    logic       load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic in_inside;    // input coordinates lie inside the edge in use
  } sts_t;

endpackage

// File: hw/rtl/p3lmt_ctrl.sv
// Controller: sequences the 27-read neighbourhood sweep and the result handshake.
module p3lmt_ctrl
  import p3lmt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_req_type,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] dp_r, dp_nxt;
  logic [1:0] dr_r, dr_nxt;
  logic [1:0] dc_r, dc_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    dp_nxt        = dp_r;
    dr_nxt        = dr_r;
    dc_nxt        = dc_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.off_p     = dp_r;
    cmd.off_r     = dr_r;
    cmd.off_c     = dc_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            dp_nxt    = OFF_MINUS;
            dr_nxt    = OFF_MINUS;
            dc_nxt    = OFF_MINUS;
            state_nxt = sts.in_inside ? S_RUN : S_DONE;
          end
        end
      end
      S_RUN: begin
        cmd.rd = 1'b1;
        if (dc_r != OFF_PLUS) begin
          dc_nxt = dc_r + 2'd1;
        end else begin
          dc_nxt = OFF_MINUS;
          if (dr_r != OFF_PLUS) begin
            dr_nxt = dr_r + 2'd1;
          end else begin
            dr_nxt = OFF_MINUS;
            if (dp_r != OFF_PLUS) begin
              dp_nxt = dp_r + 2'd1;
            end else begin
              state_nxt = S_WAIT;
            end
          end
        end
      end
      S_WAIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dp_r        <= OFF_MINUS;
      dr_r        <= OFF_MINUS;
      dc_r        <= OFF_MINUS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dp_r        <= dp_nxt;
      dr_r        <= dr_nxt;
      dc_r        <= dc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/p3lmt_dpath.sv
// Datapath: grid size register, voxel store, wrapped address generation and peak compare.
module p3lmt_dpath
  import p3lmt_pkg::*;
#(
  parameter int MAX_EDGE = MAX_EDGE_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [GS_W-1:0]          cfg_wr_data,
  input  logic [COORD_W-1:0]       in_plane,
  input  logic [COORD_W-1:0]       in_row,
  input  logic [COORD_W-1:0]       in_col,
  input  logic signed [VAL_W-1:0]  in_value,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic [COORD_W-1:0]       out_plane,
  output logic [COORD_W-1:0]       out_row,
  output logic [COORD_W-1:0]       out_col,
  output logic [STAT_W-1:0]        out_status
);

  localparam int DEPTH = MAX_EDGE * MAX_EDGE * MAX_EDGE;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $clog2(MAX_EDGE + 1);
  localparam int CW    = (EW > COORD_W) ? EW : COORD_W;

  logic signed [VAL_W-1:0] mem [DEPTH];

  logic [GS_W-1:0]         grid_size_r;
  logic [CW-1:0]           edge_w;
  logic [COORD_W-1:0]      p_r, r_r, c_r;
  logic                    inside_r;
  logic [CW-1:0]           np, nr, nc;
  logic [AW-1:0]           rd_addr, wr_addr, mem_addr;
  logic                    wr_en;
  logic signed [VAL_W-1:0] rdata_r;
  logic                    rvld_r;
  logic                    rcentre_r;
  logic signed [VAL_W-1:0] centre_r;
  logic signed [VAL_W-1:0] max_r;
  logic                    max_vld_r;
  logic [STAT_W-1:0]       status_w;
  logic [COORD_W-1:0]      out_plane_r, out_row_r, out_col_r;
  logic [STAT_W-1:0]       out_status_r;

  // One periodic step along an axis
  function automatic logic [CW-1:0] wrap_step(input logic [COORD_W-1:0] c,
                                              input logic [1:0] off,
                                              input logic [CW-1:0] e);
    logic [CW-1:0] cx;
    cx = CW'(c);
    case (off)
      OFF_MINUS: wrap_step = (cx == '0) ? e - CW'(1) : cx - CW'(1);
      OFF_PLUS:  wrap_step = (cx + CW'(1) >= e) ? '0 : cx + CW'(1);
      default:   wrap_step = cx;
    endcase
  endfunction

  function automatic logic [AW-1:0] lin_addr(input logic [CW-1:0] p,
                                             input logic [CW-1:0] r,
                                             input logic [CW-1:0] c);
    lin_addr = (AW'(p) * AW'(MAX_EDGE) + AW'(r)) * AW'(MAX_EDGE) + AW'(c);
  endfunction

  // Saturate the grid size to the supported edge range
  always_comb begin
    if (int'(grid_size_r) < EDGE_MIN) begin
      edge_w = CW'(EDGE_MIN);
    end else if (int'(grid_size_r) > MAX_EDGE) begin
      edge_w = CW'(MAX_EDGE);
    end else begin
      edge_w = CW'(grid_size_r);
    end
  end

  assign sts.in_inside = (CW'(in_plane) < edge_w) && (CW'(in_row) < edge_w) &&
                         (CW'(in_col) < edge_w);

  assign np = wrap_step(p_r, cmd.off_p, edge_w);
  assign nr = wrap_step(r_r, cmd.off_r, edge_w);
  assign nc = wrap_step(c_r, cmd.off_c, edge_w);

  assign rd_addr  = lin_addr(np, nr, nc);
  assign wr_addr  = lin_addr(CW'(in_plane), CW'(in_row), CW'(in_col));
  assign wr_en    = cmd.wr && sts.in_inside;
  assign mem_addr = wr_en ? wr_addr : rd_addr;

  // Single-port voxel store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mem_addr] <= in_value;
    end
    if (cmd.rd) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_SIZE_RST;
    end else if (cfg_wr_en) begin
      grid_size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_r      <= in_plane;
      r_r      <= in_row;
      c_r      <= in_col;
      inside_r <= sts.in_inside;
    end
  end

  // Tag returning read data: centre voxel or neighbour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r    <= 1'b0;
      rcentre_r <= 1'b0;
      max_vld_r <= 1'b0;
    end else begin
      rvld_r    <= cmd.rd;
      rcentre_r <= (cmd.off_p == OFF_ZERO) && (cmd.off_r == OFF_ZERO) &&
                   (cmd.off_c == OFF_ZERO);
      if (cmd.start) begin
        max_vld_r <= 1'b0;
      end else if (rvld_r && !rcentre_r) begin
        max_vld_r <= 1'b1;
      end
    end
  end

  // Keep the centre and a running neighbour maximum
  always_ff @(posedge clk) begin
    if (rvld_r) begin
      if (rcentre_r) begin
        centre_r <= rdata_r;
      end else if (!max_vld_r || (rdata_r > max_r)) begin
        max_r <= rdata_r;
      end
    end
  end

  always_comb begin
    if (!inside_r) begin
      status_w = ST_OOR;
    end else if (centre_r < 0) begin
      status_w = ST_NEG;
    end else if (max_vld_r && (max_r > centre_r)) begin
      status_w = ST_GREATER;
    end else begin
      status_w = ST_PEAK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_plane_r  <= p_r;
      out_row_r    <= r_r;
      out_col_r    <= c_r;
      out_status_r <= status_w;
    end
  end

  assign out_plane  = out_plane_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_status = out_status_r;

endmodule

// File: hw/rtl/periodic_3d_local_max_test.sv
// Top level of the periodic 3D local-maximum tester.
// Usage:
//   The input channel (in_valid / in_stall) carries one request per transaction.
//   A write transaction (in_req_type = 0) stores in_value at (in_plane, in_row,
//   in_col) and gives no result. A test transaction (in_req_type = 1) reads the
//   voxel and its 26 periodically wrapped neighbours and returns one result
//   transaction on out_valid / out_stall with the echoed coordinates and
//   out_status: peak, negative, greater neighbour, out of range.
//   Coordinates at or beyond the edge in use are flagged; such writes are dropped.
//   cfg_wr_en / cfg_wr_data set grid_size (clamped to 3..MAX_EDGE); write it
//   only while the block is idle.
// Sequence:
//   An in-range test makes 27 reads of the single-port voxel store, one per
//   cycle, then passes through read and compare stages before out_valid rises.
//   An out-of-range test skips the reads. in_stall stays high until the result
//   is loaded, so tests do not overlap; writes are taken one per cycle while idle.
// Reset: rst_n (synchronous, active low) clears control state and sets
//   grid_size to 32; voxel contents are undefined until written.
// Stall: hold a result in the output register while out_stall is high; the next
//   test finishes its sweep and then holds until that register is taken.
module periodic_3d_local_max_test
  import p3lmt_pkg::*;
#(
  parameter int MAX_EDGE = MAX_EDGE_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [GS_W-1:0]         cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_req_type,
  input  logic [COORD_W-1:0]      in_plane,
  input  logic [COORD_W-1:0]      in_row,
  input  logic [COORD_W-1:0]      in_col,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [COORD_W-1:0]      out_plane,
  output logic [COORD_W-1:0]      out_row,
  output logic [COORD_W-1:0]      out_col,
  output logic [STAT_W-1:0]       out_status
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: handshakes and the neighbourhood sweep
  p3lmt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Store, address wrap and compare
  p3lmt_dpath #(
    .MAX_EDGE (MAX_EDGE)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_plane    (in_plane),
    .in_row      (in_row),
    .in_col      (in_col),
    .in_value    (in_value),
    .cmd         (cmd),
    .sts         (sts),
    .out_plane   (out_plane),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_status  (out_status)
  );

endmodule
